FILE: rtl/spi_nor_flash_command_sequencer_unit_assert.svh
// Assertion macros for the serial NOR flash command sequencer.
// Used by the port monitor; no other dependencies.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define SNS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante holds -> cons holds in the next cycle
`define SNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/spinor_pkg.sv
// Shared types and constants for the serial NOR flash command sequencer.
// No dependencies.
`default_nettype none
package spinor_pkg;

   localparam int MAX_RESULTS         = 9;
   localparam int PAGE_BYTES_DEFAULT  = 256;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int ADDR_W              = 24;
   localparam int LEN_W               = 25;
   localparam int CNT_W               = $clog2(MAX_RESULTS + 1);
   localparam int UID_DUMMY_BYTES     = 4;
   localparam int UID_DATA_BYTES      = 8;
   localparam logic [LEN_W-1:0] CAPACITY_RESET = 25'd16777216;

   localparam logic [7:0] CMD_READ    = 8'h03;
   localparam logic [7:0] CMD_PROGRAM = 8'h02;
   localparam logic [7:0] CMD_WREN    = 8'h06;
   localparam logic [7:0] CMD_RDSR    = 8'h05;
   localparam logic [7:0] CMD_SE4K    = 8'h20;
   localparam logic [7:0] CMD_SE32K   = 8'h52;
   localparam logic [7:0] CMD_SE64K   = 8'hD8;
   localparam logic [7:0] CMD_CHIP    = 8'hC7;
   localparam logic [7:0] CMD_UID     = 8'h4B;
   localparam logic [7:0] CMD_SFDP    = 8'h5A;
   localparam logic [7:0] DUMMY_BYTE  = 8'h00;

   localparam logic [ADDR_W-1:0] MASK_4K  = 24'h000FFF;
   localparam logic [ADDR_W-1:0] MASK_32K = 24'h007FFF;
   localparam logic [ADDR_W-1:0] MASK_64K = 24'h00FFFF;

   localparam int STATUS_BUSY_BIT = 0;

   localparam logic [2:0] CSR_CAPACITY = 3'd0;

   typedef enum logic [1:0] {
      KIND_REQUEST,
      KIND_PROGRAM,
      KIND_RECEIVE
   } kind_type;

   typedef enum logic [2:0] {
      OP_READ,
      OP_PROGRAM,
      OP_ERASE4K,
      OP_ERASE32K,
      OP_ERASE64K,
      OP_CHIP_ERASE,
      OP_UNIQUE_ID,
      OP_SFDP
   } op_type;

   typedef enum logic [2:0] {
      ACT_SEND,
      ACT_CLOCK,
      ACT_RELEASE,
      ACT_HOST,
      ACT_DONE,
      ACT_REJECT
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PROG,
      PH_RECV,
      PH_POLL
   } phase_type;

   typedef struct packed {
      logic [7:0]        data;
      logic [LEN_W-1:0]  length;
      logic [ADDR_W-1:0] address;
      op_type            op;
   } req_word_type;

   // result list of one input word
   typedef struct packed {
      logic [CNT_W-1:0]                  cnt;
      action_type [MAX_RESULTS-1:0]      act;
      logic [MAX_RESULTS-1:0][7:0]       val;
   } script_type;

endpackage
`default_nettype wire

FILE: rtl/spi_nor_flash_command_sequencer_unit.sv
// Path: an accepted word's action list of one to nine results is registered in the queue;
// the back end then moves its results into the output register one a cycle unless stalled.
// Throughput: one word a cycle is taken while the action-list queue has room;
// the back end's single output register sets the result rate at one per cycle unless stalled.
// Reset (synchronous, active high): phase idle, queue empty, capacity 16 MiB.
// Top level of the serial NOR flash command sequencer; uses spinor_pkg.
`default_nettype none
module spi_nor_flash_command_sequencer_unit
   import spinor_pkg::*;
#(
   parameter int PAGE_BYTES  = PAGE_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // op[2:0], address[26:3], length[51:27], data[59:52]
   input  wire logic [1:0]  req_tuser,   // kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // value[7:0]
   output logic [2:0]       rsp_tuser,   // action[2:0]
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [LEN_W-1:0] capacity_ff, capacity_in;
   logic             cap_sel;
   logic             accept;
   logic             q_full;
   logic             q_valid;
   logic             q_pop;
   script_type       front_script;
   script_type       q_head;
   req_word_type     word;
   action_type       rsp_action;

   assign csr_pready = 1'b1;
   assign cap_sel    = (csr_paddr[2] == CSR_CAPACITY[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && cap_sel) begin
         capacity_in = csr_pwdata[LEN_W-1:0];
      end
      csr_prdata = cap_sel ? {(32-LEN_W)'(0), capacity_ff} : 32'h0;
   end

   assign word       = req_tdata[$bits(req_word_type)-1:0];
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   spinor_front #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .kind     (kind_type'(req_tuser)),
      .word     (word),
      .capacity (capacity_ff),
      .script   (front_script)
   );

   spinor_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_script),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   spinor_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_action (rsp_action),
      .out_value  (rsp_tdata),
      .out_last   (rsp_tlast)
   );

   assign rsp_tuser = rsp_action;

endmodule
`default_nettype wire

FILE: rtl/spinor_front.sv
// Front end: classifies accepted words, checks request rules, tracks phase
// and builds the list of bus actions for the back end. Uses spinor_pkg.
`default_nettype none
module spinor_front
   import spinor_pkg::*;
#(
   parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire kind_type         kind,
   input  wire req_word_type     word,
   input  wire logic [LEN_W-1:0] capacity,
   output script_type            script
);

   // page size is a power of two
   localparam int PAGE_LOG = $clog2(PAGE_BYTES);
   localparam int SUM_W    = LEN_W + 1;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] remaining_ff, remaining_in;

   logic [SUM_W-1:0]  end_sum;
   logic [SUM_W-1:0]  page_end;
   logic              bound_ok;
   logic              prog_ok;
   logic              erase_ok;
   logic [ADDR_W-1:0] erase_mask;
   logic [7:0]        erase_code;
   logic [LEN_W-1:0]  rem_dec;
   script_type        s;

   function automatic script_type put(script_type x, action_type a, logic [7:0] v);
      script_type r;
      r = x;
      r.act[r.cnt] = a;
      r.val[r.cnt] = v;
      r.cnt = r.cnt + CNT_W'(1);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         remaining_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
      end
   end

   always_comb begin
      end_sum  = {2'b00, word.address} + {1'b0, word.length};
      page_end = {(SUM_W-PAGE_LOG)'(0), word.address[PAGE_LOG-1:0]} + {1'b0, word.length};
      bound_ok = end_sum <= {1'b0, capacity};
      prog_ok  = (word.length != '0) && (word.length <= LEN_W'(PAGE_BYTES))
                 && (page_end <= SUM_W'(PAGE_BYTES)) && bound_ok;
      case (word.op)
         OP_ERASE4K: begin
            erase_mask = MASK_4K;
            erase_code = CMD_SE4K;
         end
         OP_ERASE32K: begin
            erase_mask = MASK_32K;
            erase_code = CMD_SE32K;
         end
         default: begin
            erase_mask = MASK_64K;
            erase_code = CMD_SE64K;
         end
      endcase
      erase_ok = ({1'b0, word.address} < capacity) && ((word.address & erase_mask) == '0);
      rem_dec  = remaining_ff - LEN_W'(1);

      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      s            = '0;

      case (kind)
         KIND_REQUEST: begin
            if (phase_ff != PH_IDLE) begin
               s = put(s, ACT_REJECT, 8'h00);
            end else begin
               case (word.op)
                  OP_READ: begin
                     if (!bound_ok) begin
                        s = put(s, ACT_REJECT, 8'h00);
                     end else begin
                        s = put(s, ACT_SEND, CMD_READ);
                        s = put(s, ACT_SEND, word.address[23:16]);
                        s = put(s, ACT_SEND, word.address[15:8]);
                        s = put(s, ACT_SEND, word.address[7:0]);
                        if (word.length == '0) begin
                           s = put(s, ACT_RELEASE, 8'h00);
                           s = put(s, ACT_DONE, 8'h00);
                           remaining_in = '0;
                        end else begin
                           s = put(s, ACT_CLOCK, 8'h00);
                           phase_in     = PH_RECV;
                           remaining_in = word.length;
                        end
                     end
                  end
                  OP_PROGRAM: begin
                     if (!prog_ok) begin
                        s = put(s, ACT_REJECT, 8'h00);
                     end else begin
                        s = put(s, ACT_SEND, CMD_WREN);
                        s = put(s, ACT_RELEASE, 8'h00);
                        s = put(s, ACT_SEND, CMD_PROGRAM);
                        s = put(s, ACT_SEND, word.address[23:16]);
                        s = put(s, ACT_SEND, word.address[15:8]);
                        s = put(s, ACT_SEND, word.address[7:0]);
                        phase_in     = PH_PROG;
                        remaining_in = word.length;
                     end
                  end
                  OP_ERASE4K, OP_ERASE32K, OP_ERASE64K: begin
                     if (!erase_ok) begin
                        s = put(s, ACT_REJECT, 8'h00);
                     end else begin
                        s = put(s, ACT_SEND, CMD_WREN);
                        s = put(s, ACT_RELEASE, 8'h00);
                        s = put(s, ACT_SEND, erase_code);
                        s = put(s, ACT_SEND, word.address[23:16]);
                        s = put(s, ACT_SEND, word.address[15:8]);
                        s = put(s, ACT_SEND, word.address[7:0]);
                        s = put(s, ACT_RELEASE, 8'h00);
                        s = put(s, ACT_SEND, CMD_RDSR);
                        s = put(s, ACT_CLOCK, 8'h00);
                        phase_in     = PH_POLL;
                        remaining_in = '0;
                     end
                  end
                  OP_CHIP_ERASE: begin
                     s = put(s, ACT_SEND, CMD_WREN);
                     s = put(s, ACT_RELEASE, 8'h00);
                     s = put(s, ACT_SEND, CMD_CHIP);
                     s = put(s, ACT_RELEASE, 8'h00);
                     s = put(s, ACT_SEND, CMD_RDSR);
                     s = put(s, ACT_CLOCK, 8'h00);
                     phase_in     = PH_POLL;
                     remaining_in = '0;
                  end
                  OP_UNIQUE_ID: begin
                     s = put(s, ACT_SEND, CMD_UID);
                     for (int i = 0; i < UID_DUMMY_BYTES; i++) begin
                        s = put(s, ACT_SEND, DUMMY_BYTE);
                     end
                     s = put(s, ACT_CLOCK, 8'h00);
                     phase_in     = PH_RECV;
                     remaining_in = LEN_W'(UID_DATA_BYTES);
                  end
                  default: begin
                     s = put(s, ACT_SEND, CMD_SFDP);
                     s = put(s, ACT_SEND, word.address[23:16]);
                     s = put(s, ACT_SEND, word.address[15:8]);
                     s = put(s, ACT_SEND, word.address[7:0]);
                     s = put(s, ACT_SEND, DUMMY_BYTE);
                     if (word.length == '0) begin
                        s = put(s, ACT_RELEASE, 8'h00);
                        s = put(s, ACT_DONE, 8'h00);
                        remaining_in = '0;
                     end else begin
                        s = put(s, ACT_CLOCK, 8'h00);
                        phase_in     = PH_RECV;
                        remaining_in = word.length;
                     end
                  end
               endcase
            end
         end
         KIND_PROGRAM: begin
            if (phase_ff == PH_PROG) begin
               s = put(s, ACT_SEND, word.data);
               remaining_in = rem_dec;
               if (rem_dec == '0) begin
                  s = put(s, ACT_RELEASE, 8'h00);
                  s = put(s, ACT_SEND, CMD_RDSR);
                  s = put(s, ACT_CLOCK, 8'h00);
                  phase_in = PH_POLL;
               end
            end else begin
               s = put(s, ACT_REJECT, 8'h00);
            end
         end
         KIND_RECEIVE: begin
            if (phase_ff == PH_RECV) begin
               s = put(s, ACT_HOST, word.data);
               remaining_in = rem_dec;
               if (rem_dec == '0) begin
                  s = put(s, ACT_RELEASE, 8'h00);
                  s = put(s, ACT_DONE, 8'h00);
                  phase_in = PH_IDLE;
               end else begin
                  s = put(s, ACT_CLOCK, 8'h00);
               end
            end else if (phase_ff == PH_POLL) begin
               s = put(s, ACT_RELEASE, 8'h00);
               remaining_in = '0;
               if (word.data[STATUS_BUSY_BIT]) begin
                  s = put(s, ACT_SEND, CMD_RDSR);
                  s = put(s, ACT_CLOCK, 8'h00);
               end else begin
                  s = put(s, ACT_DONE, 8'h00);
                  phase_in = PH_IDLE;
               end
            end else begin
               s = put(s, ACT_REJECT, 8'h00);
            end
         end
         default: begin
            s = put(s, ACT_REJECT, 8'h00);
         end
      endcase
      script = s;
   end

endmodule
`default_nettype wire

FILE: rtl/spinor_queue.sv
// Short queue of action lists between front end and back end.
// Uses spinor_pkg.
`default_nettype none
module spinor_queue
   import spinor_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire script_type push_data,
   output logic            full,
   input  wire logic       pop,
   output logic            not_empty,
   output script_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   script_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

endmodule
`default_nettype wire

FILE: rtl/spinor_back.sv
// Back end: plays out the queued action lists into the output register, one result word
// per cycle while the output is not stalled. Uses spinor_pkg.
`default_nettype none
module spinor_back
   import spinor_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   input  wire script_type q_head,
   output logic            q_pop,
   output logic            out_valid,
   input  wire logic       out_ready,
   output action_type      out_action,
   output logic [7:0]      out_value,
   output logic            out_last
);

   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   action_type       action_ff, action_in;
   logic [7:0]       value_ff, value_in;
   logic             last_ff, last_in;
   logic             load;
   logic             at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   always_comb begin
      load      = q_valid && (!valid_ff || out_ready);
      at_end    = (idx_ff == q_head.cnt - CNT_W'(1));
      q_pop     = load && at_end;
      idx_in    = idx_ff;
      valid_in  = valid_ff && !out_ready;
      action_in = action_ff;
      value_in  = value_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in  = 1'b1;
         action_in = q_head.act[idx_ff];
         value_in  = q_head.val[idx_ff];
         last_in   = at_end;
         idx_in    = at_end ? '0 : idx_ff + CNT_W'(1);
      end
   end

   assign out_valid  = valid_ff;
   assign out_action = action_ff;
   assign out_value  = value_ff;
   assign out_last   = last_ff;

endmodule
`default_nettype wire

FILE: rtl/spinor_monitor.sv
// Port monitor for the serial NOR flash command sequencer, bound to the top.
// Uses spinor_pkg and spi_nor_flash_command_sequencer_unit_assert.svh.
`default_nettype none
`include "spi_nor_flash_command_sequencer_unit_assert.svh"
module spinor_monitor
   import spinor_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [2:0] rsp_tuser,
   input wire logic       rsp_tlast
);

   `SNS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result word changed while stalled")
   `SNS_ASSERT_SAME(a_reject_last, clock, reset, rsp_tvalid && (rsp_tuser == ACT_REJECT), rsp_tlast, "reject not the last result")
   `SNS_ASSERT_SAME(a_done_last, clock, reset, rsp_tvalid && (rsp_tuser == ACT_DONE), rsp_tlast, "done not the last result")
   `SNS_ASSERT_SAME(a_zero_value, clock, reset, rsp_tvalid && ((rsp_tuser == ACT_CLOCK) || (rsp_tuser == ACT_RELEASE) || (rsp_tuser == ACT_DONE) || (rsp_tuser == ACT_REJECT)), rsp_tdata == 8'h00, "nonzero value on a control result")

endmodule

bind spi_nor_flash_command_sequencer_unit spinor_monitor u_monitor (.*);
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking bench for spi_nor_flash_command_sequencer_unit: streams request, program
// and flash-byte words, predicts every bus action and compares them in order.
// Depends on spinor_pkg and the sequencer RTL.
`timescale 1ns / 100ps

module testbench;
   import spinor_pkg::*;

   localparam logic [1:0]  KIND_INVALID    = 2'd3;
   localparam int unsigned PAGE            = PAGE_BYTES_DEFAULT;
   localparam int          HOLD_CYCLES     = 150;
   localparam int          WATCHDOG_CYCLES = 3000;

   typedef struct {
      action_type action;
      logic [7:0] value;
      logic       last;
   } bus_action_type;

   function automatic logic [23:0] sector_mask(op_type op);
      case (op)
         OP_ERASE4K:  return MASK_4K;
         OP_ERASE32K: return MASK_32K;
         default:     return MASK_64K;
      endcase
   endfunction

   // tracks sequencer state and the bus actions still owed
   class flash_action_board;
      logic [24:0]    capacity;
      phase_type      phase;
      logic [24:0]    remaining;
      bus_action_type awaited_actions[$];
      int             checked;
      int             errors;

      function new();
         capacity  = CAPACITY_RESET;
         phase     = PH_IDLE;
         remaining = '0;
         checked   = 0;
         errors    = 0;
      endfunction

      function void add(action_type act, logic [7:0] value);
         bus_action_type item;
         item.action = act;
         item.value  = value;
         item.last   = 1'b0;
         awaited_actions.push_back(item);
      endfunction

      function void add_address(logic [23:0] addr);
         add(ACT_SEND, addr[23:16]);
         add(ACT_SEND, addr[15:8]);
         add(ACT_SEND, addr[7:0]);
      endfunction

      function void open_receive(logic [24:0] count);
         if (count == 0) begin
            add(ACT_RELEASE, 8'h00);
            add(ACT_DONE, 8'h00);
            phase     = PH_IDLE;
            remaining = '0;
         end else begin
            add(ACT_CLOCK, 8'h00);
            phase     = PH_RECV;
            remaining = count;
         end
      endfunction

      function void open_poll();
         add(ACT_SEND, CMD_RDSR);
         add(ACT_CLOCK, 8'h00);
         phase     = PH_POLL;
         remaining = '0;
      endfunction

      function void note_word(logic [1:0] kind, op_type op, logic [23:0] addr,
                              logic [24:0] len, logic [7:0] data);
         logic [25:0]    span;
         logic [23:0]    mask;
         logic [7:0]     code;
         bus_action_type tail;
         span = {2'b00, addr} + {1'b0, len};
         if (kind == KIND_REQUEST) begin
            if (phase != PH_IDLE) begin
               add(ACT_REJECT, 8'h00);
            end else begin
               case (op)
                  OP_READ: begin
                     if (span > {1'b0, capacity}) begin
                        add(ACT_REJECT, 8'h00);
                     end else begin
                        add(ACT_SEND, CMD_READ);
                        add_address(addr);
                        open_receive(len);
                     end
                  end
                  OP_PROGRAM: begin
                     if (len == 0 || len > PAGE || addr / PAGE != (span - 1) / PAGE
                         || span > {1'b0, capacity}) begin
                        add(ACT_REJECT, 8'h00);
                     end else begin
                        add(ACT_SEND, CMD_WREN);
                        add(ACT_RELEASE, 8'h00);
                        add(ACT_SEND, CMD_PROGRAM);
                        add_address(addr);
                        phase     = PH_PROG;
                        remaining = len;
                     end
                  end
                  OP_ERASE4K, OP_ERASE32K, OP_ERASE64K: begin
                     mask = sector_mask(op);
                     code = (op == OP_ERASE4K) ? CMD_SE4K :
                            (op == OP_ERASE32K) ? CMD_SE32K : CMD_SE64K;
                     if (addr >= capacity || (addr & mask) != 0) begin
                        add(ACT_REJECT, 8'h00);
                     end else begin
                        add(ACT_SEND, CMD_WREN);
                        add(ACT_RELEASE, 8'h00);
                        add(ACT_SEND, code);
                        add_address(addr);
                        add(ACT_RELEASE, 8'h00);
                        open_poll();
                     end
                  end
                  OP_CHIP_ERASE: begin
                     add(ACT_SEND, CMD_WREN);
                     add(ACT_RELEASE, 8'h00);
                     add(ACT_SEND, CMD_CHIP);
                     add(ACT_RELEASE, 8'h00);
                     open_poll();
                  end
                  OP_UNIQUE_ID: begin
                     add(ACT_SEND, CMD_UID);
                     repeat (UID_DUMMY_BYTES) add(ACT_SEND, DUMMY_BYTE);
                     open_receive(25'(UID_DATA_BYTES));
                  end
                  default: begin
                     add(ACT_SEND, CMD_SFDP);
                     add_address(addr);
                     add(ACT_SEND, DUMMY_BYTE);
                     open_receive(len);
                  end
               endcase
            end
         end else if (kind == KIND_PROGRAM && phase == PH_PROG) begin
            add(ACT_SEND, data);
            remaining = remaining - 1'b1;
            if (remaining == 0) begin
               add(ACT_RELEASE, 8'h00);
               open_poll();
            end
         end else if (kind == KIND_RECEIVE && phase == PH_RECV) begin
            add(ACT_HOST, data);
            remaining = remaining - 1'b1;
            if (remaining == 0) begin
               add(ACT_RELEASE, 8'h00);
               add(ACT_DONE, 8'h00);
               phase = PH_IDLE;
            end else begin
               add(ACT_CLOCK, 8'h00);
            end
         end else if (kind == KIND_RECEIVE && phase == PH_POLL) begin
            add(ACT_RELEASE, 8'h00);
            if (data[STATUS_BUSY_BIT]) begin
               open_poll();
            end else begin
               add(ACT_DONE, 8'h00);
               phase     = PH_IDLE;
               remaining = '0;
            end
         end else begin
            add(ACT_REJECT, 8'h00);
         end
         tail      = awaited_actions.pop_back();
         tail.last = 1'b1;
         awaited_actions.push_back(tail);
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("mismatch %0d at %0t: %s", errors, $time, what);
      endfunction

      function void check_action(action_type act, logic [7:0] value, logic last);
         bus_action_type want;
         checked++;
         if (awaited_actions.size() == 0) begin
            flag($sformatf("unexpected action %0d value %02h last %0b", act, value, last));
            return;
         end
         want = awaited_actions.pop_front();
         if (act !== want.action || value !== want.value || last !== want.last)
            flag($sformatf("expected action %0d value %02h last %0b, got %0d %02h %0b",
                           want.action, want.value, want.last, act, value, last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // op[2:0], address[26:3], length[51:27], data[59:52]
   logic [1:0]  req_tuser;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // value[7:0]
   logic [2:0]  rsp_tuser;   // action[2:0]
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   flash_action_board board = new();
   int   words_sent = 0;
   int   settings   = 0;
   logic calm       = 1'b0;
   logic hold_off   = 1'b0;

   spi_nor_flash_command_sequencer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // one word on the request channel; valid stays up for a back-to-back word
   task automatic send_word(input logic [1:0] kind, input op_type op, input logic [23:0] addr,
                            input logic [24:0] len, input logic [7:0] data);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, data, len, addr, op};
      do @(posedge clock); while (!req_tready);
      board.note_word(kind, op, addr, len, data);
      words_sent++;
      if (words_sent == 60) hold_off = 1'b1;
      if (words_sent == 280) calm = 1'b1;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.awaited_actions.size() != 0);
   endtask

   task automatic run_phase(input logic [24:0] cap, input int words);
      int          stop;
      int          lo;
      int unsigned room;
      int unsigned pick;
      op_type      op;
      logic [1:0]  kind;
      logic [23:0] addr;
      logic [24:0] len;
      logic [7:0]  data;
      stop = words_sent + words;
      drain();
      repeat (4) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_CAPACITY;
      csr_pwdata  <= {7'd0, cap};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.capacity = cap;
      settings++;
      while (words_sent < stop) begin
         op   = op_type'($urandom_range(0, 7));
         addr = 24'($urandom);
         len  = 25'($urandom);
         data = 8'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // stray byte while idle
            kind = 2'($urandom_range(1, 3));
            send_word(kind, op, addr, len, data);
         end else begin
            if (pick < 20) begin
               // request that breaks a rule
               case ($urandom_range(0, 3))
                  0: begin
                     op  = OP_READ;
                     lo  = (int'(cap) >= int'(addr)) ? int'(cap) - int'(addr) + 1 : 0;
                     len = 25'($urandom_range(lo, 25'h1FFFFFF));
                  end
                  1: begin
                     op  = OP_PROGRAM;
                     len = $urandom_range(0, 1) ? 25'd0
                                                : 25'($urandom_range(PAGE + 1, 25'h1FFFFFF));
                  end
                  2: begin
                     op   = OP_PROGRAM;
                     lo   = $urandom_range(1, PAGE - 1);
                     addr = 24'(addr - addr % PAGE + lo);
                     len  = 25'($urandom_range(PAGE + 1 - lo, PAGE));
                  end
                  default: begin
                     op = op_type'($urandom_range(OP_ERASE4K, OP_ERASE64K));
                     if ((addr & sector_mask(op)) == 0) addr[0] = 1'b1;
                  end
               endcase
            end else begin
               case (op)
                  OP_READ, OP_SFDP: begin
                     len = 25'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                           : $urandom_range(0, 8));
                     if (op == OP_READ) begin
                        if (len > cap) len = cap;
                        room = {7'd0, cap - len};
                        addr = 24'($urandom_range(0, room > 24'hFFFFFF ? 24'hFFFFFF : room));
                     end
                  end
                  OP_PROGRAM: begin
                     len  = ($urandom_range(0, 39) == 0) ? 25'(PAGE)
                                                         : 25'($urandom_range(1, 16));
                     room = cap / PAGE;
                     addr = 24'((room == 0 ? 0 : $urandom_range(0, room - 1)) * PAGE
                                + $urandom_range(0, PAGE - len));
                  end
                  OP_ERASE4K, OP_ERASE32K, OP_ERASE64K: begin
                     addr = 24'((cap == 0 ? $urandom : $urandom_range(0, cap - 1))
                                & ~sector_mask(op));
                  end
                  default: ;
               endcase
            end
            send_word(KIND_REQUEST, op, addr, len, data);
            // carry the operation through its data and status phases
            while (board.phase != PH_IDLE) begin
               op   = op_type'($urandom_range(0, 7));
               addr = 24'($urandom);
               len  = 25'($urandom);
               data = 8'($urandom);
               if ($urandom_range(0, 19) == 0) begin
                  // busy request or wrong kind of byte
                  kind = 2'($urandom_range(0, 3));
                  if (kind == KIND_PROGRAM && board.phase == PH_PROG) kind = KIND_INVALID;
                  if (kind == KIND_RECEIVE && board.phase != PH_PROG) kind = KIND_INVALID;
               end else if (board.phase == PH_PROG) begin
                  kind = KIND_PROGRAM;
               end else begin
                  kind = KIND_RECEIVE;
                  if (board.phase == PH_POLL) data[STATUS_BUSY_BIT] = ($urandom_range(0, 2) == 0);
               end
               send_word(kind, op, addr, len, data);
            end
         end
      end
   endtask

   // result side: random stalls, plus one long hold-off to back up the input
   initial begin
      forever begin
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_action(action_type'(rsp_tuser), rsp_tdata, rsp_tlast);
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty read and empty SFDP frames
      send_word(KIND_REQUEST, OP_READ, 24'h000000, 25'd0, 8'h00);
      send_word(KIND_REQUEST, OP_SFDP, 24'hFFFFFF, 25'd0, 8'hFF);
      // last byte of the array, then a read past the end
      send_word(KIND_REQUEST, OP_READ, 24'hFFFFFF, 25'd1, 8'h00);
      send_word(KIND_RECEIVE, OP_READ, 24'h000000, 25'd0, 8'hFF);
      send_word(KIND_REQUEST, OP_READ, 24'h000001, 25'h1FFFFFF, 8'h00);
      // page program rules
      send_word(KIND_REQUEST, OP_PROGRAM, 24'h000100, 25'd0, 8'h00);
      send_word(KIND_REQUEST, OP_PROGRAM, 24'h0000FF, 25'd2, 8'h00);
      send_word(KIND_REQUEST, OP_PROGRAM, 24'h000000, 25'd257, 8'h00);
      send_word(KIND_REQUEST, OP_PROGRAM, 24'hFFFFFF, 25'd1, 8'h00);
      send_word(KIND_PROGRAM, OP_READ, 24'h000000, 25'd0, 8'hA5);
      send_word(KIND_RECEIVE, OP_READ, 24'h000000, 25'd0, 8'h01);
      send_word(KIND_RECEIVE, OP_READ, 24'h000000, 25'd0, 8'h00);
      // sector erases, busy request and a stray byte during status polling
      send_word(KIND_REQUEST, OP_ERASE4K, 24'h000800, 25'd0, 8'h00);
      send_word(KIND_REQUEST, OP_ERASE32K, 24'hFF8000, 25'd0, 8'h00);
      send_word(KIND_REQUEST, OP_CHIP_ERASE, 24'h000000, 25'd0, 8'h00);
      send_word(KIND_PROGRAM, OP_READ, 24'h000000, 25'd0, 8'h3C);
      send_word(KIND_RECEIVE, OP_READ, 24'h000000, 25'd0, 8'hFE);
      send_word(KIND_REQUEST, OP_ERASE64K, 24'hFF0000, 25'd0, 8'h00);
      send_word(KIND_RECEIVE, OP_READ, 24'h000000, 25'd0, 8'h00);
      send_word(KIND_REQUEST, OP_CHIP_ERASE, 24'hFFFFFF, 25'h1FFFFFF, 8'h00);
      send_word(KIND_RECEIVE, OP_READ, 24'h000000, 25'd0, 8'h00);
      // stray bytes while idle
      send_word(KIND_PROGRAM, OP_READ, 24'h000000, 25'd0, 8'h55);
      send_word(KIND_RECEIVE, OP_READ, 24'h000000, 25'd0, 8'hAA);
      send_word(KIND_INVALID, OP_SFDP, 24'h000000, 25'd0, 8'h00);

      run_phase(CAPACITY_RESET, 110);
      run_phase(25'd0, 12);
      run_phase(25'd1, 12);
      run_phase(25'h0010000, 50);
      run_phase(25'($urandom_range(2, 25'h1000000)), 50);
      run_phase(25'h0FFFFFF, 70);

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d words and %0d bus actions across %0d capacity settings",
               words_sent, board.checked, settings);
      $display("including a %0d-cycle output hold-off; %0d mismatches",
               HOLD_CYCLES, board.errors);
      if (board.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
